// ===== sv/mvpi_pkg.sv =====
// Package for the PI velocity drive: widths, register indexes and sequencer states.
// Used by every module of the block; depends on nothing.
package mvpi_pkg;
  localparam int WordW = 32;
  localparam int AccW = 66;
  localparam int DutyW = 11;
  localparam int DutyFull = 1000;
  localparam logic [30:0] MaxVoltageReset = 31'd65536;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegPropGain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEmfGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTorqueGain = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPulseScale = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxVelocity = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxTorque = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMaxVoltage = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEL, ST_ERR, ST_UP, ST_UI, ST_TORQ, ST_VT, ST_VE, ST_VOLT,
    ST_DMUL, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } mul_ctl_t;

  function automatic logic signed [WordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    begin
      hi = AccW'(64'sh7fffffff);
      lo = -AccW'(64'sh80000000);
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[WordW-1:0];
    end
  endfunction

  function automatic logic signed [WordW-1:0] clampmag(input logic signed [WordW-1:0] v,
                                                       input logic [30:0] lim);
    logic signed [WordW:0] l;
    logic signed [WordW:0] w;
    begin
      l = {2'b00, lim};
      w = {v[WordW-1], v};
      if (w > l) clampmag = l[WordW-1:0];
      else if (w < -l) clampmag = WordW'(-l);
      else clampmag = v;
    end
  endfunction
endpackage

// ===== sv/mvpi_serial_mul.sv =====
// Bit-serial signed 32 by 32 multiplier and unsigned divider of the held product by a
// 32-bit divisor (one bit a cycle). Depends on mvpi_pkg.
module mvpi_serial_mul (
  input  logic clk,
  input  logic rst,
  input  mvpi_pkg::mul_ctl_t ctl,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic busy,
  output logic signed [63:0] product,
  output logic [31:0] quotient
);
  import mvpi_pkg::*;

  logic [5:0] cnt;
  logic div_mode;
  logic signed [63:0] acc;
  logic signed [63:0] mcand;
  logic [31:0] mplier;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      div_mode <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      div_mode <= ctl.is_div;
      acc <= '0;
      mcand <= 64'(a);
      mplier <= b;
      rem <= acc[63:32];
      quo <= acc[31:0];
      dvs <= b;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
      if (div_mode) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
      end else begin
        if (mplier[0]) begin
          if (cnt == 6'd1) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
    end
  end

  assign product = acc;
  assign quotient = quo;
endmodule

// ===== sv/mvpi_regs.sv =====
// Configuration register file for the PI velocity drive.
// Depends on mvpi_pkg.
module mvpi_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mvpi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic signed [31:0] prop_gain,
  output logic signed [31:0] int_gain,
  output logic signed [31:0] emf_gain,
  output logic signed [31:0] torque_gain,
  output logic signed [31:0] pulse_scale,
  output logic [30:0] max_velocity,
  output logic [30:0] max_torque,
  output logic [30:0] max_voltage
);
  import mvpi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= '0;
      int_gain <= '0;
      emf_gain <= '0;
      torque_gain <= '0;
      pulse_scale <= '0;
      max_velocity <= '0;
      max_torque <= '0;
      max_voltage <= MaxVoltageReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPropGain: prop_gain <= cfg_data;
        RegIntGain: int_gain <= cfg_data;
        RegEmfGain: emf_gain <= cfg_data;
        RegTorqueGain: torque_gain <= cfg_data;
        RegPulseScale: pulse_scale <= cfg_data;
        RegMaxVelocity: max_velocity <= cfg_data[30:0];
        RegMaxTorque: max_torque <= cfg_data[30:0];
        RegMaxVoltage: max_voltage <= cfg_data[30:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/motor_velocity_pi_voltage_drive.sv =====
// Top level of the PI velocity drive with back-EMF feedforward.
// A running tick makes six serial multiplies and one serial divide on one shared unit, plus
// four single steps, from the accepting edge to the result word. A zero voltage limit
// skips the duty multiply and divide; a shutdown tick skips all of them.
// One word at a time: the next is accepted only after the result has been taken.
// Synchronous active-high reset clears the controller state, the shutdown latch and the
// registers (max_voltage resets to 1.0).
module motor_velocity_pi_voltage_drive (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mvpi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] pulse_count,
  input  logic signed [31:0] target_command,
  input  logic enable_pin,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [mvpi_pkg::DutyW-1:0] duty,
  output logic gate_enable,
  output logic faulted
);
  import mvpi_pkg::*;

  logic signed [31:0] prop_gain, int_gain, emf_gain, torque_gain, pulse_scale;
  logic [30:0] max_velocity, max_torque, max_voltage;

  state_t state, state_next;
  logic signed [15:0] pulses;
  logic signed [31:0] target;
  logic signed [31:0] last_error, torque_accum, velocity, error, up, ui;
  logic signed [AccW-1:0] vt;
  logic signed [31:0] voltage;
  logic shutdown_latch;
  logic neg;
  mul_ctl_t mctl;
  logic signed [31:0] ma, mb;
  logic busy;
  logic signed [63:0] product;
  logic [31:0] quotient;
  logic signed [AccW-1:0] pq;
  logic signed [AccW-1:0] sum;

  mvpi_regs u_regs (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .prop_gain, .int_gain, .emf_gain, .torque_gain, .pulse_scale,
    .max_velocity, .max_torque, .max_voltage
  );

  mvpi_serial_mul u_mul (
    .clk, .rst, .ctl(mctl), .a(ma), .b(mb), .busy, .product, .quotient
  );

  assign pq = AccW'(product >>> 16);
  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    mctl = '0;
    ma = '0;
    mb = '0;
    case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_VEL;
      ST_VEL: begin
        if (shutdown_latch) state_next = ST_DONE;
        else begin
          mctl.start = 1'b1;
          ma = 32'(pulses);
          mb = pulse_scale;
          state_next = ST_ERR;
        end
      end
      ST_ERR: if (!busy) begin
        mctl.start = 1'b1;
        ma = prop_gain;
        mb = sat32(AccW'(sat32(AccW'(clampmag(target, max_velocity))
               - AccW'(sat32(AccW'(product))))) - AccW'(last_error));
        state_next = ST_UP;
      end
      ST_UP: if (!busy) begin
        mctl.start = 1'b1;
        ma = int_gain;
        mb = error;
        state_next = ST_UI;
      end
      ST_UI: if (!busy) state_next = ST_TORQ;
      ST_TORQ: begin
        mctl.start = 1'b1;
        ma = clampmag(sat32(AccW'(torque_accum) + AccW'(up) + AccW'(ui)), max_torque);
        mb = torque_gain;
        state_next = ST_VT;
      end
      ST_VT: if (!busy) begin
        mctl.start = 1'b1;
        ma = velocity;
        mb = emf_gain;
        state_next = ST_VE;
      end
      ST_VE: if (!busy) state_next = ST_VOLT;
      ST_VOLT: begin
        if (max_voltage == '0) state_next = ST_DONE;
        else begin
          mctl.start = 1'b1;
          ma = voltage[31] ? -voltage : voltage;
          mb = 32'sd1000;
          state_next = ST_DMUL;
        end
      end
      ST_DMUL: if (!busy) begin
        mctl.start = 1'b1;
        mctl.is_div = 1'b1;
        mb = {1'b0, max_voltage};
        state_next = ST_DIV;
      end
      ST_DIV: if (!busy) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign sum = pq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      shutdown_latch <= 1'b0;
      last_error <= '0;
      torque_accum <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          pulses <= pulse_count;
          target <= target_command;
          if (!enable_pin) shutdown_latch <= 1'b1;
        end
        ST_ERR: if (!busy) begin
          velocity <= sat32(AccW'(product));
          error <= sat32(AccW'(clampmag(target, max_velocity))
                   - AccW'(sat32(AccW'(product))));
        end
        ST_UP: if (!busy) up <= sat32(sum);
        ST_UI: if (!busy) ui <= sat32(sum);
        ST_TORQ: begin
          torque_accum <= ma;
          last_error <= error;
        end
        ST_VT: if (!busy) vt <= sum;
        ST_VE: if (!busy) begin
          voltage <= clampmag(sat32(vt + sum), max_voltage);
        end
        ST_VOLT: begin
          neg <= voltage[31];
          duty <= '0;
        end
        ST_DIV: if (!busy) duty <= neg ? -DutyW'(quotient) : DutyW'(quotient);
        ST_DONE: begin
          out_valid <= 1'b1;
          gate_enable <= !shutdown_latch;
          faulted <= shutdown_latch;
          if (shutdown_latch) begin
            duty <= '0;
            last_error <= '0;
            torque_accum <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !busy) else $error("input ready while the multiplier is busy");
  a_fault_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (faulted != gate_enable)) else $error("fault and gate enable disagree");
  a_fault_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && faulted) |-> (duty == '0)) else $error("nonzero duty while faulted");
  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(shutdown_latch) |-> shutdown_latch) else $error("shutdown latch cleared");
endmodule

// ===== sim/testbench.sv =====
// Testbench for the PI velocity drive: directed table, randomised control ticks under bursty
// input and stalling output, shutdown ticks; checked against the table or a behavioural predictor.
// Depends on mvpi_pkg and motor_velocity_pi_voltage_drive.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mvpi_pkg::*;

  typedef struct {
    logic signed [DutyW-1:0] duty;
    logic gate;
    logic fault;
  } drive_out_t;

  typedef struct {
    int phase;
    logic signed [15:0] pulses;
    logic signed [31:0] target;
    logic pin;
    bit typed;
    drive_out_t want;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] pulse_count = '0;
  logic signed [31:0] target_command = '0;
  logic enable_pin = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DutyW-1:0] duty;
  logic gate_enable;
  logic faulted;

  motor_velocity_pi_voltage_drive u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pulse_count(pulse_count),
    .target_command(target_command), .enable_pin(enable_pin), .out_valid(out_valid),
    .out_ready(out_ready), .duty(duty), .gate_enable(gate_enable), .faulted(faulted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of registers and controller state.
  longint k_prop, k_int, k_emf, k_torque, k_pulse;
  longint lim_vel, lim_trq, lim_volt;
  longint last_err, trq_acc;
  bit halted;

  drive_out_t duty_queue[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int saturated_duty = 0;
  int burst_left = 0;
  bit long_hold = 1'b0;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  task automatic predict_drive(input logic signed [15:0] p, input logic signed [31:0] t,
                               input logic en, output drive_out_t r);
    longint vel, tgt, err, derr, up, ui, trq, volt, dty;
    if (!en) halted = 1'b1;
    if (halted) begin
      last_err = 0;
      trq_acc = 0;
      r = '{duty: '0, gate: 1'b0, fault: 1'b1};
      return;
    end
    vel = sat32(longint'(p) * k_pulse);
    tgt = clamp_mag(longint'(t), lim_vel);
    err = sat32(tgt - vel);
    derr = sat32(err - last_err);
    up = sat32(qmul(k_prop, derr));
    ui = sat32(qmul(k_int, err));
    trq = clamp_mag(sat32(trq_acc + up + ui), lim_trq);
    trq_acc = trq;
    volt = clamp_mag(sat32(qmul(trq_acc, k_torque) + qmul(vel, k_emf)), lim_volt);
    dty = (lim_volt == 0) ? 0 : (volt * 1000) / lim_volt;
    last_err = err;
    r = '{duty: dty[DutyW-1:0], gate: 1'b1, fault: 1'b0};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d (word %0d)", what, got, want, words_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    drive_out_t w;
    if (!rst && out_valid && out_ready) begin
      if (duty_queue.size() == 0) begin
        report_mismatch("unexpected word, duty", duty, 0);
      end else begin
        w = duty_queue.pop_front();
        if (duty !== w.duty) report_mismatch("duty", duty, w.duty);
        if (gate_enable !== w.gate) report_mismatch("gate_enable", gate_enable, w.gate);
        if (faulted !== w.fault) report_mismatch("faulted", faulted, w.fault);
        if (duty == 1000 || duty == -1000) saturated_duty++;
        words_checked++;
      end
    end
  end

  // Receiver: randomly changing stall pattern, plus one long hold-off on request.
  initial begin
    int mode;
    mode = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      RegPropGain: k_prop = longint'($signed(v));
      RegIntGain: k_int = longint'($signed(v));
      RegEmfGain: k_emf = longint'($signed(v));
      RegTorqueGain: k_torque = longint'($signed(v));
      RegPulseScale: k_pulse = longint'($signed(v));
      RegMaxVelocity: lim_vel = longint'(v[30:0]);
      RegMaxTorque: lim_trq = longint'(v[30:0]);
      default: lim_volt = longint'(v[30:0]);
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_word(input logic signed [15:0] p, input logic signed [31:0] t,
                           input logic en, input bit typed, input drive_out_t want);
    drive_out_t r;
    in_valid <= 1'b1;
    pulse_count <= p;
    target_command <= t;
    enable_pin <= en;
    do @(posedge clk); while (!in_ready);
    predict_drive(p, t, en, r);
    duty_queue.push_back(typed ? want : r);
    words_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic setup_phase(input int ph);
    case (ph)
      1: begin
        set_reg(RegPropGain, 32'h0002_0000);
        set_reg(RegIntGain, 32'h0000_8000);
        set_reg(RegEmfGain, 32'h0001_0000);
        set_reg(RegTorqueGain, 32'h0003_0000);
        set_reg(RegPulseScale, 32'h0001_0000);
        set_reg(RegMaxVelocity, 32'h7fff_ffff);
        set_reg(RegMaxTorque, 32'h7fff_ffff);
        set_reg(RegMaxVoltage, 32'h0);
      end
      2: set_reg(RegMaxVoltage, 32'h00c0_0000);
      3: begin
        set_reg(RegPropGain, 32'h7fff_ffff);
        set_reg(RegIntGain, 32'h8000_0000);
        set_reg(RegEmfGain, 32'h8000_0000);
        set_reg(RegTorqueGain, 32'h7fff_ffff);
        set_reg(RegPulseScale, 32'h8000_0000);
        set_reg(RegMaxVoltage, 32'h7fff_ffff);
      end
      4: begin
        set_reg(RegMaxVelocity, 32'h0);
        set_reg(RegMaxTorque, 32'h0);
        set_reg(RegEmfGain, 32'h0000_4000);
        set_reg(RegPulseScale, 32'h0000_1000);
        set_reg(RegMaxVoltage, 32'h0001_0000);
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return {1'b0, 31'($urandom_range(0, 32'h7fff_ffff))};
      default: return $urandom_range(1 << 14, 1 << 26);
    endcase
  endfunction

  tick_row_t ticks[] = '{
    '{0, 16'sd0, 32'sd0, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{0, 16'sh7fff, 32'sh7fff_ffff, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{0, 16'sh8000, 32'sh8000_0000, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{0, -16'sd1, -32'sd1, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{1, 16'sd100, 32'sh0010_0000, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{1, -16'sd100, -32'sh0010_0000, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{1, 16'sh7fff, 32'sh7fff_ffff, 1'b1, 1, '{11'sd0, 1'b1, 1'b0}},
    '{2, 16'sd3, 32'sh0008_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{2, 16'sd5, 32'sh0008_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{2, 16'sd8, 32'sh0008_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{2, -16'sd40, 32'sh0040_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{2, 16'sd60, -32'sh0040_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{3, 16'sh7fff, 32'sh8000_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{3, 16'sh8000, 32'sh7fff_ffff, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{3, 16'sd1, 32'sd0, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{3, -16'sd1, 32'sd1, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{4, 16'sd200, 32'sh0100_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}},
    '{4, -16'sd300, -32'sh0100_0000, 1'b1, 0, '{11'sd0, 1'b0, 1'b0}}
  };

  tick_row_t shutdown_ticks[] = '{
    '{5, 16'sd5, 32'sd1000, 1'b0, 1, '{11'sd0, 1'b0, 1'b1}},
    '{5, 16'sd7, 32'sh0004_0000, 1'b1, 1, '{11'sd0, 1'b0, 1'b1}}
  };

  initial begin
    int ph;
    logic signed [15:0] p;
    logic signed [31:0] t;
    drive_out_t none;
    none = '{duty: '0, gate: 1'b0, fault: 1'b0};
    k_prop = 0; k_int = 0; k_emf = 0; k_torque = 0; k_pulse = 0;
    lim_vel = 0; lim_trq = 0; lim_volt = 65536;
    last_err = 0; trq_acc = 0; halted = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ph = 0;
    foreach (ticks[i]) begin
      if (ticks[i].phase != ph) begin
        wait_idle();
        ph = ticks[i].phase;
        setup_phase(ph);
      end
      send_word(ticks[i].pulses, ticks[i].target, ticks[i].pin, ticks[i].typed, ticks[i].want);
    end

    for (int k = 0; k < 8; k++) begin
      wait_idle();
      set_reg(RegPropGain, pick_gain());
      set_reg(RegIntGain, pick_gain());
      set_reg(RegEmfGain, pick_gain());
      set_reg(RegTorqueGain, pick_gain());
      set_reg(RegPulseScale, ($urandom_range(0, 3) == 0) ? pick_gain()
                             : $urandom_range(1 << 10, 1 << 18));
      set_reg(RegMaxVelocity, pick_limit());
      set_reg(RegMaxTorque, pick_limit());
      set_reg(RegMaxVoltage, ($urandom_range(0, 9) == 0) ? pick_limit()
                             : $urandom_range(1 << 16, 1 << 28));
      if (k == 2) long_hold = 1'b1;
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          p = 16'($urandom);
          t = $urandom;
        end else begin
          p = 16'($signed($urandom_range(0, 400)) - 200);
          t = 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        end
        send_word(p, t, 1'b1, 0, none);
      end
    end

    wait_idle();
    foreach (shutdown_ticks[i])
      send_word(shutdown_ticks[i].pulses, shutdown_ticks[i].target, shutdown_ticks[i].pin,
                1, shutdown_ticks[i].want);
    for (int n = 0; n < 12; n++)
      send_word(16'($urandom), $urandom, 1'($urandom_range(0, 1)), 0, none);

    wait_idle();
    $display("Sent %0d control ticks over 8 random register settings and the directed cases;",
             words_sent);
    $display("checked %0d words, %0d of them at full duty, ending in latched shutdown.",
             words_checked, saturated_duty);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d words still awaited.", duty_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== motor_velocity_pi_voltage_drive.f =====
sv/mvpi_pkg.sv
sv/mvpi_serial_mul.sv
sv/mvpi_regs.sv
sv/motor_velocity_pi_voltage_drive.sv
sim/testbench.sv
